/* rtl/npp_pkg.sv */
// Shared widths, beat types and register indexes for the nearest point on polyline block.
package npp_pkg;

  // Coordinate width and the widths of the arithmetic that follow from it
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;       // vertex and query differences
  localparam int MUL_W   = DIFF_W + 1;        // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DOT_W   = 2 * DIFF_W + 1;    // signed dot product
  localparam int NRM_W   = 2 * DIFF_W;        // squared segment length
  localparam int MAG_W   = NRM_W + COORD_W + 1;
  localparam int NUM_W   = MAG_W + 2;         // 2*mag + nrm
  localparam int DEN_W   = NRM_W + 1;         // 2*nrm
  localparam int QUO_W   = DIFF_W;
  localparam int REM_W   = NUM_W - QUO_W;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int DIST_W  = 2 * COORD_W + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   first_vertex;
    logic   last_vertex;
  } in_beat_t;

  typedef struct packed {
    coord_t              nearest_x;
    coord_t              nearest_y;
    logic [DIST_W-1:0]   nearest_dist_sq;
  } out_beat_t;

  // Queue head offered to the back end
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } queue_head_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/nearest_point_on_polyline_top.sv */
// Top level of the nearest point on polyline block: query registers and unit wiring.
//
// Usage: write the query point through the cfg_ channel (index 0 = x, 1 = y,
// signed Q12.4) while the block is idle; cfg_ready is always high. Vertex beats
// enter on in_valid/in_stall; first_vertex starts a polyline, last_vertex asks
// for a result. One result beat per last vertex leaves on out_valid/out_stall
// with the nearest point and its squared distance (Q.8).
// An accepted beat is registered in the queue before the back end sees it.
// A first vertex goes straight to the distance steps; a degenerate or clamped
// segment first runs the dot product, length and decide steps, and a segment
// with an interior projection also runs the restoring divider once per axis,
// at one quotient bit per cycle, using the shared 18x18 multiplier for each
// product. out_valid rises after the emit step once the output register is
// free.
// A two-entry queue takes beats while the back end is busy; in_stall rises
// only when it is full. A stalled result holds in the output register, and
// the back end waits on it before loading the next one.
// Reset: synchronous, active low; clears the query point, previous vertex,
// best point, queue and output valid.
module nearest_point_on_polyline_top import npp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  coord_t      query_x_r, query_y_r;
  queue_head_t head;
  logic        pop;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  assign cfg_ready = 1'b1;

  // Query point registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_x_r <= '0;
      query_y_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_QUERY_X) query_x_r <= cfg_wdata;
      if (cfg_index == REG_QUERY_Y) query_y_r <= cfg_wdata;
    end
  end

  npp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  npp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  npp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .query_x   (query_x_r),
    .query_y   (query_y_r),
    .head      (head),
    .pop       (pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/npp_front.sv */
// Front end: accepts vertex beats into a two-entry queue for the back end.
module npp_front import npp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output queue_head_t head,
  input  logic        pop
);

  in_beat_t    mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  logic        do_pop;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != 2'd0);

  assign head.valid = (count_r != 2'd0);
  assign head.beat  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

endmodule

/* rtl/npp_div.sv */
// Restoring divider, one quotient bit per cycle, for the projection offset.
module npp_div import npp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [QUO_W-1:0] lo_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [REM_W-1:0] trial;
  logic             ge;

  assign trial = {rem_r[REM_W-2:0], lo_r[QUO_W-1]};
  assign ge    = (trial >= REM_W'(den_r));

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[NUM_W-1:QUO_W];
      lo_r  <= req.num[QUO_W-1:0];
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= ge ? (trial - REM_W'(den_r)) : trial;
      lo_r  <= {lo_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/npp_back.sv */
// Back end: projects the query onto each segment, keeps the running best, drives results.
module npp_back import npp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  coord_t      query_x,
  input  coord_t      query_y,
  input  queue_head_t head,
  output logic        pop,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_DOT0   = 13'b0000000000010,
    ST_DOT1   = 13'b0000000000100,
    ST_NRM0   = 13'b0000000001000,
    ST_NRM1   = 13'b0000000010000,
    ST_DECIDE = 13'b0000000100000,
    ST_PLO    = 13'b0000001000000,
    ST_PHI    = 13'b0000010000000,
    ST_DLOAD  = 13'b0000100000000,
    ST_DIV    = 13'b0001000000000,
    ST_DST0   = 13'b0010000000000,
    ST_DST1   = 13'b0100000000000,
    ST_EMIT   = 13'b1000000000000
  } state_t;

  state_t                    state_r;
  coord_t                    ax_r, ay_r;
  coord_t                    bx_r, by_r;
  logic                      last_r;
  logic signed [DIFF_W-1:0]  abx_r, aby_r, apx_r, apy_r;
  logic signed [DOT_W-1:0]   dot_r;
  logic [NRM_W-1:0]          nrm_r;
  logic [MAG_W-1:0]          mag_r;
  logic                      axis_r;
  coord_t                    cx_r, cy_r;
  logic [DIST_W-1:0]         dist_r;
  logic                      first_r;
  logic                      seen_r;
  coord_t                    best_x_r, best_y_r;
  logic [DIST_W-1:0]         best_d_r;
  out_beat_t                 out_r;
  logic                      out_valid_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIFF_W-1:0]  ab_sel;
  logic [DIFF_W-1:0]         ab_mag;
  logic signed [DIFF_W-1:0]  dcx, dcy;
  logic signed [DIFF_W-1:0]  a_sel;
  logic signed [DIFF_W-1:0]  c_sum;
  logic [DIST_W-1:0]         d_new;
  logic                      out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pop       = (state_r == ST_IDLE) && head.valid;

  // Axis operand for the offset multiply and divide
  assign ab_sel = axis_r ? aby_r : abx_r;
  assign ab_mag = ab_sel[DIFF_W-1] ? DIFF_W'(-ab_sel) : DIFF_W'(ab_sel);
  assign a_sel  = axis_r ? {ay_r[COORD_W-1], ay_r} : {ax_r[COORD_W-1], ax_r};
  assign c_sum  = ab_sel[DIFF_W-1] ? (a_sel - $signed(div_rsp.quot))
                                   : (a_sel + $signed(div_rsp.quot));

  // Query minus candidate point
  assign dcx = {query_x[COORD_W-1], query_x} - {cx_r[COORD_W-1], cx_r};
  assign dcy = {query_y[COORD_W-1], query_y} - {cy_r[COORD_W-1], cy_r};

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_DOT0: begin
        mul_a = {apx_r[DIFF_W-1], apx_r};
        mul_b = {abx_r[DIFF_W-1], abx_r};
      end
      ST_DOT1: begin
        mul_a = {apy_r[DIFF_W-1], apy_r};
        mul_b = {aby_r[DIFF_W-1], aby_r};
      end
      ST_NRM0: begin
        mul_a = {abx_r[DIFF_W-1], abx_r};
        mul_b = {abx_r[DIFF_W-1], abx_r};
      end
      ST_NRM1: begin
        mul_a = {aby_r[DIFF_W-1], aby_r};
        mul_b = {aby_r[DIFF_W-1], aby_r};
      end
      ST_PLO: begin
        mul_a = {1'b0, ab_mag};
        mul_b = {1'b0, dot_r[DIFF_W-1:0]};
      end
      ST_PHI: begin
        mul_a = {1'b0, ab_mag};
        mul_b = {1'b0, dot_r[2*DIFF_W-1:DIFF_W]};
      end
      ST_DST0: begin
        mul_a = {dcx[DIFF_W-1], dcx};
        mul_b = {dcx[DIFF_W-1], dcx};
      end
      ST_DST1: begin
        mul_a = {dcy[DIFF_W-1], dcy};
        mul_b = {dcy[DIFF_W-1], dcy};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign d_new = dist_r + prod[DIST_W-1:0];

  // Divider request: round(mag / nrm) as (2*mag + nrm) / (2*nrm)
  assign div_req.start = (state_r == ST_DLOAD);
  assign div_req.num   = {mag_r, 1'b0} + NUM_W'(nrm_r);
  assign div_req.den   = {nrm_r, 1'b0};

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r     <= '0;
      ay_r     <= '0;
      best_x_r <= '0;
      best_y_r <= '0;
      best_d_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            bx_r    <= head.beat.vertex_x;
            by_r    <= head.beat.vertex_y;
            first_r <= head.beat.first_vertex;
            last_r  <= head.beat.last_vertex;
            cx_r    <= head.beat.vertex_x;
            cy_r    <= head.beat.vertex_y;
            abx_r   <= {head.beat.vertex_x[COORD_W-1], head.beat.vertex_x}
                       - {ax_r[COORD_W-1], ax_r};
            aby_r   <= {head.beat.vertex_y[COORD_W-1], head.beat.vertex_y}
                       - {ay_r[COORD_W-1], ay_r};
            apx_r   <= {query_x[COORD_W-1], query_x} - {ax_r[COORD_W-1], ax_r};
            apy_r   <= {query_y[COORD_W-1], query_y} - {ay_r[COORD_W-1], ay_r};
          end
        end
        ST_DOT0: dot_r <= prod[DOT_W-1:0];
        ST_DOT1: dot_r <= dot_r + prod[DOT_W-1:0];
        ST_NRM0: nrm_r <= prod[NRM_W-1:0];
        ST_NRM1: nrm_r <= nrm_r + prod[NRM_W-1:0];
        ST_DECIDE: begin
          axis_r <= 1'b0;
          if (nrm_r == '0 || dot_r[DOT_W-1] || dot_r == '0) begin
            cx_r <= ax_r;
            cy_r <= ay_r;
          end else if (dot_r[DOT_W-2:0] >= nrm_r) begin
            cx_r <= bx_r;
            cy_r <= by_r;
          end
        end
        ST_PLO: mag_r <= MAG_W'(prod[NRM_W-1:0]);
        ST_PHI: mag_r <= mag_r + MAG_W'({prod[NRM_W-1:0], {DIFF_W{1'b0}}});
        ST_DIV: begin
          if (div_rsp.done) begin
            if (axis_r) begin
              cy_r <= c_sum[COORD_W-1:0];
            end else begin
              cx_r   <= c_sum[COORD_W-1:0];
              axis_r <= 1'b1;
            end
          end
        end
        ST_DST0: dist_r <= prod[DIST_W-1:0];
        ST_DST1: begin
          if (first_r || !seen_r || d_new < best_d_r) begin
            best_x_r <= cx_r;
            best_y_r <= cy_r;
            best_d_r <= d_new;
          end
          ax_r <= bx_r;
          ay_r <= by_r;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_r.nearest_x       <= best_x_r;
            out_r.nearest_y       <= best_y_r;
            out_r.nearest_dist_sq <= best_d_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            state_r <= head.beat.first_vertex ? ST_DST0 : ST_DOT0;
          end
        end
        ST_DOT0: state_r <= ST_DOT1;
        ST_DOT1: state_r <= ST_NRM0;
        ST_NRM0: state_r <= ST_NRM1;
        ST_NRM1: state_r <= ST_DECIDE;
        ST_DECIDE: begin
          if (nrm_r == '0 || dot_r[DOT_W-1] || dot_r == '0 ||
              dot_r[DOT_W-2:0] >= nrm_r) begin
            state_r <= ST_DST0;
          end else begin
            state_r <= ST_PLO;
          end
        end
        ST_PLO:   state_r <= ST_PHI;
        ST_PHI:   state_r <= ST_DLOAD;
        ST_DLOAD: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            state_r <= axis_r ? ST_DST0 : ST_PLO;
          end
        end
        ST_DST0: state_r <= ST_DST1;
        ST_DST1: begin
          seen_r  <= !first_r;
          state_r <= last_r ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DLOAD) |-> (nrm_r != '0))
    else $error("divide started with zero segment length");

  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> last_r)
    else $error("result emitted for a vertex not marked last");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule

/* bench/nearest_point_on_polyline_top_tb.sv */
// Testbench for the nearest point on polyline block: directed table, random polylines, scoreboard.
`timescale 1ns / 100ps

module nearest_point_on_polyline_top_tb;
  import npp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_wdata;

  nearest_point_on_polyline_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predictor state
  coord_t            qry_x, qry_y;
  coord_t            last_vx, last_vy;
  bit                have_seg;
  coord_t            near_x, near_y;
  logic [DIST_W-1:0] near_d;

  out_beat_t expected_q[$];
  int        n_errors;
  int        idle_cycles;
  int        send_idle_pct, recv_stall_pct;
  bit        done_flag;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic logic [DIST_W-1:0] dist_sq(longint px, longint py, longint cx,
                                                longint cy);
    longint dx, dy;
    dx = px - cx;
    dy = py - cy;
    return DIST_W'(dx * dx + dy * dy);
  endfunction

  // Rounded division, ties away from zero; den > 0
  function automatic longint div_round(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  // Advance the predictor by one vertex; returns 1 when a result is due
  function automatic bit predict_vertex(in_beat_t b, output out_beat_t res);
    longint px, py, bx, by, ax, ay, abx, aby, dot, nrm, cx, cy;
    logic [DIST_W-1:0] d;
    px = qry_x; py = qry_y;
    bx = b.vertex_x; by = b.vertex_y;
    if (b.first_vertex) begin
      have_seg = 0;
      near_x = b.vertex_x;
      near_y = b.vertex_y;
      near_d = dist_sq(px, py, bx, by);
    end else begin
      ax = last_vx; ay = last_vy;
      abx = bx - ax; aby = by - ay;
      dot = (px - ax) * abx + (py - ay) * aby;
      nrm = abx * abx + aby * aby;
      if (nrm == 0 || dot <= 0) begin
        cx = ax; cy = ay;
      end else if (dot >= nrm) begin
        cx = bx; cy = by;
      end else begin
        cx = ax + div_round(abx * dot, nrm);
        cy = ay + div_round(aby * dot, nrm);
      end
      d = dist_sq(px, py, cx, cy);
      if (!have_seg || d < near_d) begin
        near_x = coord_t'(cx);
        near_y = coord_t'(cy);
        near_d = d;
      end
      have_seg = 1;
    end
    last_vx = b.vertex_x;
    last_vy = b.vertex_y;
    res.nearest_x = near_x;
    res.nearest_y = near_y;
    res.nearest_dist_sq = near_d;
    return b.last_vertex;
  endfunction

  // Directed rows: vertex, flags, and a typed expectation where obvious
  typedef struct {
    coord_t            vx, vy;
    bit                first, last;
    bit                typed;
    coord_t            ex, ey;
    logic [DIST_W-1:0] ed;
  } vec_row_t;

  localparam int N_ROWS = 20;
  vec_row_t rows[N_ROWS];

  initial begin
    // after reset, no first mark: segment from (0,0) to (16,0); query at origin
    rows[0]  = '{16'sd16, 16'sd0, 0, 1, 1, 16'sd0, 16'sd0, 0};
    // lone vertex at the extremes
    rows[1]  = '{-16'sd32768, -16'sd32768, 1, 1, 1, -16'sd32768, -16'sd32768,
                 33'd2147483648};
    rows[2]  = '{16'sd32767, 16'sd32767, 1, 1, 1, 16'sd32767, 16'sd32767, 33'd2147352578};
    rows[3]  = '{16'sd32767, -16'sd32768, 1, 1, 0, 0, 0, 0};
    // segment with an interior projection
    rows[4]  = '{-16'sd100, 16'sd50, 1, 0, 0, 0, 0, 0};
    rows[5]  = '{16'sd100, 16'sd40, 0, 0, 0, 0, 0, 0};
    // zero-length segment
    rows[6]  = '{16'sd100, 16'sd40, 0, 0, 0, 0, 0, 0};
    // clamped before the start
    rows[7]  = '{16'sd300, 16'sd300, 0, 1, 0, 0, 0, 0};
    // extension after a last mark without a first mark
    rows[8]  = '{-16'sd7, 16'sd3, 0, 1, 0, 0, 0, 0};
    // extreme-length segments
    rows[9]  = '{-16'sd32768, 16'sd32767, 1, 0, 0, 0, 0, 0};
    rows[10] = '{16'sd32767, -16'sd32768, 0, 1, 0, 0, 0, 0};
    rows[11] = '{-16'sd32768, -16'sd32768, 1, 0, 0, 0, 0, 0};
    rows[12] = '{16'sd32767, 16'sd32767, 0, 0, 0, 0, 0, 0};
    rows[13] = '{16'sd32767, -16'sd32768, 0, 1, 0, 0, 0, 0};
    // equal distances: the earliest segment wins
    rows[14] = '{-16'sd20, 16'sd10, 1, 0, 0, 0, 0, 0};
    rows[15] = '{16'sd20, 16'sd10, 0, 0, 0, 0, 0, 0};
    rows[16] = '{16'sd20, -16'sd10, 0, 0, 0, 0, 0, 0};
    rows[17] = '{-16'sd20, -16'sd10, 0, 1, 0, 0, 0, 0};
    // first and last together after a running polyline
    rows[18] = '{16'sd5, -16'sd5, 1, 1, 1, 16'sd5, -16'sd5, 33'd50};
    rows[19] = '{16'sd1, 16'sd1, 0, 1, 0, 0, 0, 0};
  end

  // Drive one vertex beat and predict it at acceptance; valid stays high after
  task automatic send_vertex(in_beat_t b, bit typed, out_beat_t typed_res);
    out_beat_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_vertex(b, res))
      expected_q.insert(expected_q.size(), typed ? typed_res : res);
  endtask

  // Wait until the block is idle, then write one query register
  task automatic write_query(logic [CFG_IDX_W-1:0] idx, coord_t val);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_QUERY_X) qry_x = val;
    else qry_y = val;
  endtask

  function automatic coord_t rand_coord(int spread);
    case (spread)
      0: return coord_t'($urandom_range(65535));
      1: return coord_t'(int'($urandom_range(4000)) - 2000);
      default: return $urandom_range(1) ? 16'sh7fff - coord_t'($urandom_range(3))
                                         : 16'sh8000 + coord_t'($urandom_range(3));
    endcase
  endfunction

  // Receiver: random stall and scoreboard
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          n_errors++;
        end else begin
          out_beat_t e;
          e = expected_q.pop_front();
          if (out_data.nearest_x !== e.nearest_x)
            report_mismatch("nearest_x", out_data.nearest_x, e.nearest_x);
          if (out_data.nearest_y !== e.nearest_y)
            report_mismatch("nearest_y", out_data.nearest_y, e.nearest_y);
          if (out_data.nearest_dist_sq !== e.nearest_dist_sq)
            report_mismatch("nearest_dist_sq", out_data.nearest_dist_sq, e.nearest_dist_sq);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (!done_flag && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    in_beat_t  b;
    out_beat_t t;
    int        n, spread;
    n_errors = 0; idle_cycles = 0; done_flag = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    qry_x = 0; qry_y = 0; last_vx = 0; last_vy = 0;
    have_seg = 0; near_x = 0; near_y = 0; near_d = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_valid = 1'b0; cfg_index = REG_QUERY_X; cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, query at reset value first
    for (int i = 0; i < N_ROWS; i++) begin
      if (i == 4) begin
        write_query(REG_QUERY_X, 16'sd10);
        write_query(REG_QUERY_Y, 16'sd77);
      end
      if (i == 14) begin
        write_query(REG_QUERY_X, 16'sd0);
        write_query(REG_QUERY_Y, 16'sd0);
      end
      b.vertex_x = rows[i].vx; b.vertex_y = rows[i].vy;
      b.first_vertex = rows[i].first; b.last_vertex = rows[i].last;
      t.nearest_x = rows[i].ex; t.nearest_y = rows[i].ey;
      t.nearest_dist_sq = rows[i].ed;
      send_vertex(b, rows[i].typed, t);
    end

    // Random polylines over idling phases and query settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      case (phase)
        1: begin write_query(REG_QUERY_X, 16'sh7fff); write_query(REG_QUERY_Y, 16'sh8000); end
        2: begin write_query(REG_QUERY_X, 16'sh8000); write_query(REG_QUERY_Y, 16'sh7fff); end
        default: begin
          write_query(REG_QUERY_X, rand_coord($urandom_range(1)));
          write_query(REG_QUERY_Y, rand_coord($urandom_range(1)));
        end
      endcase
      n = 0;
      while (n < 205) begin
        int len;
        len = $urandom_range(5) + 1;
        spread = ($urandom_range(9) < 6) ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
        for (int k = 0; k < len; k++) begin
          b.vertex_x = rand_coord(spread);
          b.vertex_y = rand_coord(spread);
          // mostly well-formed polylines, some broken marks
          b.first_vertex = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
          b.last_vertex  = (k == len - 1) ? ($urandom_range(9) != 0)
                                          : ($urandom_range(29) == 0);
          if (k > 0 && $urandom_range(15) == 0) begin
            b.vertex_x = last_vx; b.vertex_y = last_vy;
          end
          send_vertex(b, 0, t);
          n++;
        end
      end
    end

    // Drain
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    done_flag = 1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/npp_pkg.sv
rtl/npp_front.sv
rtl/npp_div.sv
rtl/npp_back.sv
rtl/nearest_point_on_polyline_top.sv
bench/nearest_point_on_polyline_top_tb.sv
